// ----- src/proximity_neighbor_table_macros.svh -----
// Assertion macros shared by the neighbor table RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef PROXIMITY_NEIGHBOR_TABLE_MACROS_SVH
`define PROXIMITY_NEIGHBOR_TABLE_MACROS_SVH

// condition holds in the same cycle
`define PNT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define PNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pnt_pkg.sv -----
// Shared types and constants for the proximity neighbor table.
// No dependencies.
package pnt_pkg;

	localparam int NODE_W  = 6;
	localparam int POS_W   = 16;
	localparam int MAP_W   = 64;
	localparam int RANGE_W = 33;
	localparam logic [RANGE_W-1:0] RANGE_RESET = 33'd250000;

	localparam logic [1:0] KIND_MOVE   = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
		logic [MAP_W-1:0]  map;
		logic              changed;
	} res_t;

	typedef struct packed {
		logic              live;
		logic              last;
		logic [NODE_W-1:0] idx;
	} tag_t;

endpackage

// ----- src/proximity_neighbor_table.sv -----
// Top level of the proximity neighbor table: range register on the APB port
// and the item sequencer. Depends on pnt_pkg and pnt_core.
//
//  channel   direction  handshake                 payload
//  item      in         start & !busy             kind, node, pos_x, pos_y
//  result    out        done (one-cycle strobe)   node_echo, neighbor_map, changed
//  config    in         psel & penable & pwrite   paddr, pwdata (range_squared at 0)
//
// An in-range item makes one pass over the link and position memories, one
// entry per cycle, then drains the read/distance pipeline and writes the
// node's row before its result is shown.
// The next item can be accepted at the edge that ends the result cycle.
// An item with node at or beyond MAX_NODES returns its result next cycle.
// Reset clears the link matrix through per-row valid bits; no clearing pass.
// busy is low again in the cycle the result is shown; results cannot stall.
module proximity_neighbor_table #(
	parameter int MAX_NODES  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 kind,
	input  logic [pnt_pkg::NODE_W-1:0] node,
	input  logic [pnt_pkg::POS_W-1:0]  pos_x,
	input  logic [pnt_pkg::POS_W-1:0]  pos_y,
	output logic                       done,
	output logic [pnt_pkg::NODE_W-1:0] node_echo,
	output logic [pnt_pkg::MAP_W-1:0]  neighbor_map,
	output logic                       changed,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready
);
	import pnt_pkg::*;

	logic [RANGE_W-1:0] range_q;
	logic               cfg_wr;
	res_t               res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];
	assign prdata = paddr[3] ? 64'd0 : 64'(range_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_RESET;
		end else if (cfg_wr) begin
			range_q <= pwdata[RANGE_W-1:0];
		end
	end

	pnt_core #(.MAX_NODES(MAX_NODES), .COORD_BITS(COORD_BITS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.kind     (kind),
		.node     (node),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.range_sq (range_q),
		.busy     (busy),
		.res      (res)
	);

	assign done         = res.valid;
	assign node_echo    = res.node;
	assign neighbor_map = res.map;
	assign changed      = res.changed;

endmodule

// ----- src/pnt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pnt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/pnt_dist.sv -----
// Three-stage squared-distance compare: abs diff, square, sum and compare.
// Depends on pnt_pkg.
module pnt_dist #(
	parameter int CW = 16
) (
	input  logic                        clk,
	input  logic [CW-1:0]               a_x,
	input  logic [CW-1:0]               a_y,
	input  logic [CW-1:0]               b_x,
	input  logic [CW-1:0]               b_y,
	input  logic [pnt_pkg::RANGE_W-1:0] range_sq,
	output logic                        near_s4
);
	import pnt_pkg::*;

	localparam int SW = 2 * CW + 1;

	logic [CW-1:0]   dx_s2, dy_s2;
	logic [2*CW-1:0] sqx_s3, sqy_s3;
	logic [SW-1:0]   sum;

	assign sum = SW'(sqx_s3) + SW'(sqy_s3);

	always_ff @(posedge clk) begin
		dx_s2   <= (a_x > b_x) ? (a_x - b_x) : (b_x - a_x);
		dy_s2   <= (a_y > b_y) ? (a_y - b_y) : (b_y - a_y);
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		near_s4 <= RANGE_W'(sum) < range_sq;
	end

endmodule

// ----- src/pnt_core.sv -----
// Item sequencer: sweeps the position and link memories once per in-range item,
// read-modify-writes each affected peer's link row on a move or remove and assembles the node's row.
// Depends on pnt_pkg, pnt_ram, pnt_dist and the assertion macro header.
`include "proximity_neighbor_table_macros.svh"

module pnt_core #(
	parameter int MAX_NODES  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  kind,
	input  logic [pnt_pkg::NODE_W-1:0]  node,
	input  logic [pnt_pkg::POS_W-1:0]   pos_x,
	input  logic [pnt_pkg::POS_W-1:0]   pos_y,
	input  logic [pnt_pkg::RANGE_W-1:0] range_sq,
	output logic                        busy,
	output pnt_pkg::res_t               res
);
	import pnt_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SWEEP  = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t st_q;
	logic [NW-1:0] cnt_q;
	logic [NW-1:0] node_q;
	logic          move_q, remove_q;
	logic [CW-1:0] x_q, y_q;
	logic          changed_q;
	logic [MAX_NODES-1:0] acc_q;
	logic [MAX_NODES-1:0] present_q;
	logic [MAX_NODES-1:0] row_vld_q;
	res_t res_q;

	tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic rd_vld_s1;
	logic [MAX_NODES-1:0] row_s1, row_s2, row_s3, row_s4;
	logic [MAX_NODES-1:0] lk_rdata;
	logic [2*CW-1:0]      pos_rdata;
	logic                 near_s4;

	logic accept, in_range;
	logic pos_we;
	logic lk_we;
	logic [NW-1:0] lk_waddr;
	logic [MAX_NODES-1:0] lk_wdata;

	logic [NW-1:0] idx4;
	logic apply4, on4, old4;
	logic [MAX_NODES-1:0] wrow4;

	assign accept   = start && (st_q == ST_IDLE);
	assign in_range = int'(node) < MAX_NODES;
	assign pos_we   = accept && in_range && (kind == KIND_MOVE);
	assign busy     = (st_q != ST_IDLE);
	assign res      = res_q;

	pnt_ram #(.WIDTH(2 * CW), .DEPTH(MAX_NODES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (node[NW-1:0]),
		.wdata ({pos_x[CW-1:0], pos_y[CW-1:0]}),
		.raddr (cnt_q),
		.rdata (pos_rdata)
	);

	pnt_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (cnt_q),
		.rdata (lk_rdata)
	);

	pnt_dist #(.CW(CW)) u_dist (
		.clk      (clk),
		.a_x      (x_q),
		.a_y      (y_q),
		.b_x      (pos_rdata[2*CW-1:CW]),
		.b_y      (pos_rdata[CW-1:0]),
		.range_sq (range_sq),
		.near_s4  (near_s4)
	);

	// rows never written read as empty
	assign row_s1 = lk_rdata & {MAX_NODES{rd_vld_s1}};

	// by symmetry, bit node of row idx is bit idx of the node's own row
	always_comb begin
		idx4   = tag_s4.idx[NW-1:0];
		old4   = row_s4[node_q];
		apply4 = tag_s4.live && (idx4 != node_q) &&
		         (remove_q || (move_q && present_q[idx4]));
		on4    = move_q && near_s4;
		wrow4  = row_s4;
		wrow4[node_q] = on4;
	end

	always_comb begin
		if (st_q == ST_FINISH) begin
			lk_we    = move_q || remove_q;
			lk_waddr = node_q;
			lk_wdata = acc_q;
		end else begin
			lk_we    = apply4;
			lk_waddr = idx4;
			lk_wdata = wrow4;
		end
	end

	always_ff @(posedge clk) begin
		row_s2 <= row_s1;
		row_s3 <= row_s2;
		row_s4 <= row_s3;
		if (accept) begin
			node_q   <= node[NW-1:0];
			move_q   <= (kind == KIND_MOVE);
			remove_q <= (kind == KIND_REMOVE);
			x_q      <= pos_x[CW-1:0];
			y_q      <= pos_y[CW-1:0];
		end
		if (tag_s4.live) begin
			acc_q[idx4] <= apply4 ? on4 : old4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			changed_q <= 1'b0;
			present_q <= '0;
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			tag_s1    <= '0;
			tag_s2    <= '0;
			tag_s3    <= '0;
			tag_s4    <= '0;
			res_q     <= '0;
		end else begin
			res_q.valid <= 1'b0;
			rd_vld_s1   <= row_vld_q[cnt_q];
			tag_s2      <= tag_s1;
			tag_s3      <= tag_s2;
			tag_s4      <= tag_s3;
			tag_s1      <= '0;
			if (lk_we) begin
				row_vld_q[lk_waddr] <= 1'b1;
			end
			if (apply4 && (old4 != on4)) begin
				changed_q <= 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					changed_q <= 1'b0;
					if (accept) begin
						if (!in_range) begin
							res_q.valid   <= 1'b1;
							res_q.node    <= node;
							res_q.map     <= '0;
							res_q.changed <= 1'b0;
						end else begin
							st_q <= ST_SWEEP;
							if (kind == KIND_MOVE) begin
								present_q[node[NW-1:0]] <= 1'b1;
							end
						end
					end
				end
				ST_SWEEP: begin
					tag_s1.live <= 1'b1;
					tag_s1.last <= (cnt_q == NW'(MAX_NODES - 1));
					tag_s1.idx  <= NODE_W'(cnt_q);
					cnt_q       <= cnt_q + 1'b1;
					if (cnt_q == NW'(MAX_NODES - 1)) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (tag_s4.live && tag_s4.last) begin
						st_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					st_q          <= ST_IDLE;
					res_q.valid   <= 1'b1;
					res_q.node    <= NODE_W'(node_q);
					res_q.map     <= MAP_W'(acc_q);
					res_q.changed <= changed_q;
					if (remove_q) begin
						present_q[node_q] <= 1'b0;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PNT_ASSERT_NOW(a_own_row_untouched, clk, arst_n,
		((st_q == ST_SWEEP) || (st_q == ST_DRAIN)) && lk_we,
		lk_waddr != node_q, "peer write hit the item's own row")
	`PNT_ASSERT_NOW(a_no_rw_overlap, clk, arst_n,
		(st_q == ST_SWEEP) && lk_we,
		lk_waddr != cnt_q, "link row written while being read")
	`PNT_ASSERT_NEXT(a_finish_reports, clk, arst_n,
		st_q == ST_FINISH,
		res_q.valid && !busy, "finished item gave no result")

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for proximity_neighbor_table. It sends move, remove and query transactions,
// predicts each neighbor report, and checks it. It also changes the range over APB.
// Depends on pnt_pkg and the proximity_neighbor_table RTL.
module tb;
	import pnt_pkg::*;

	localparam int NODES = 64;
	localparam int ITEM_LATENCY = NODES + 7;
	localparam logic [1:0] KIND_QUERY_ALT = 2'd3;
	localparam logic [3:0] ADDR_RANGE = 4'd0;
	localparam logic [RANGE_W-1:0] RANGE_MAX = '1;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [NODE_W-1:0] node;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
	} move_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [MAP_W-1:0]  map;
		logic              changed;
	} nbr_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	move_item_t cur_item = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;

	logic busy, done, changed, pready;
	logic [NODE_W-1:0] node_echo;
	logic [MAP_W-1:0] neighbor_map;
	logic [63:0] prdata;

	// behavioral copy of the table
	bit [POS_W-1:0] x_tab [NODES];
	bit [POS_W-1:0] y_tab [NODES];
	bit present_tab [NODES];
	bit [MAP_W-1:0] link_tab [NODES];
	bit [RANGE_W-1:0] range_cfg = RANGE_RESET;

	move_item_t item_queue [$];
	nbr_report_t report_queue [$];
	int accepted_count = 0;
	int mismatches = 0;
	logic calm;

	proximity_neighbor_table #(
		.MAX_NODES(NODES),
		.COORD_BITS(POS_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(cur_item.kind),
		.node(cur_item.node),
		.pos_x(cur_item.x),
		.pos_y(cur_item.y),
		.done(done),
		.node_echo(node_echo),
		.neighbor_map(neighbor_map),
		.changed(changed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial forever #2 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("tb: mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
		mismatches++;
	endtask

	function automatic nbr_report_t apply_to_table(input move_item_t it);
		nbr_report_t r;
		logic [63:0] dx, dy, d2;
		logic on;
		r.node = it.node;
		r.changed = 1'b0;
		case (it.kind)
		KIND_MOVE: begin
			x_tab[it.node] = it.x;
			y_tab[it.node] = it.y;
			present_tab[it.node] = 1'b1;
			for (int i = 0; i < NODES; i++) begin
				if (i != it.node && present_tab[i]) begin
					dx = 64'((it.x > x_tab[i]) ? it.x - x_tab[i] : x_tab[i] - it.x);
					dy = 64'((it.y > y_tab[i]) ? it.y - y_tab[i] : y_tab[i] - it.y);
					d2 = dx * dx + dy * dy;
					on = (d2 < {31'b0, range_cfg});
					if (link_tab[it.node][i] != on)
						r.changed = 1'b1;
					link_tab[it.node][i] = on;
					link_tab[i][it.node] = on;
				end
			end
		end
		KIND_REMOVE: begin
			for (int i = 0; i < NODES; i++) begin
				if (i != it.node) begin
					if (link_tab[it.node][i])
						r.changed = 1'b1;
					link_tab[i][it.node] = 1'b0;
				end
			end
			link_tab[it.node] = '0;
			present_tab[it.node] = 1'b0;
		end
		default: begin
			// query, including the spare kind code
		end
		endcase
		r.map = link_tab[it.node];
		return r;
	endfunction

	assign calm = (accepted_count >= 600) && (accepted_count < 900);

	// driver: one transaction in flight at most, random gaps outside the calm stretch
	always @(posedge clk) begin
		nbr_report_t rep;
		if (arst_n) begin
			if (start && !busy) begin
				rep = apply_to_table(cur_item);
				report_queue = {report_queue, rep};
				accepted_count <= accepted_count + 1;
			end
			if (!start || !busy) begin
				if (item_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
					start <= 1'b1;
					cur_item <= item_queue.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		nbr_report_t want;
		if (arst_n && done) begin
			if (report_queue.size() == 0) begin
				report_mismatch("unexpected result, node", '0, 64'(node_echo));
			end else begin
				want = report_queue.pop_front();
				if (node_echo !== want.node)
					report_mismatch("node_echo", 64'(want.node), 64'(node_echo));
				if (neighbor_map !== want.map)
					report_mismatch("neighbor_map", want.map, neighbor_map);
				if (changed !== want.changed)
					report_mismatch("changed", 64'(want.changed), 64'(changed));
			end
		end
	end

	task automatic apb_cycle(input logic wr, input logic [63:0] wdata,
			output logic [63:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_RANGE;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_range_read();
		logic [63:0] rd;
		apb_cycle(1'b0, '0, rd);
		if (rd[RANGE_W-1:0] !== range_cfg)
			report_mismatch("range_squared readback", 64'(range_cfg), rd);
	endtask

	task automatic set_range(input logic [RANGE_W-1:0] v);
		logic [63:0] rd;
		apb_cycle(1'b1, {31'b0, v}, rd);
		range_cfg = v;
		check_range_read();
	endtask

	task automatic push_item(input logic [1:0] k, input int n, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y);
		move_item_t it;
		it = '{kind: k, node: n[NODE_W-1:0], x: x, y: y};
		item_queue = {item_queue, it};
	endtask

	task automatic drain();
		while (item_queue.size() != 0 || start || busy || report_queue.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic run_random(input int count, input int span);
		int k, n, mode;
		logic [1:0] kd;
		logic [POS_W-1:0] bx, by, x, y;
		bx = POS_W'($urandom_range(0, 65535));
		by = POS_W'($urandom_range(0, 65535));
		repeat (count) begin
			k = $urandom_range(0, 99);
			kd = (k < 60) ? KIND_MOVE : (k < 75) ? KIND_REMOVE :
				(k < 88) ? KIND_QUERY : KIND_QUERY_ALT;
			// mostly a dozen busy nodes so links build up
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NODES - 1) : $urandom_range(0, 11);
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				x = POS_W'($urandom_range(0, 65535));
				y = POS_W'($urandom_range(0, 65535));
			end else if (mode == 1) begin
				x = $urandom_range(0, 1) ? POS_MAX : '0;
				y = $urandom_range(0, 1) ? POS_MAX : '0;
			end else begin
				x = POS_W'(bx + $urandom_range(0, span));
				y = POS_W'(by + $urandom_range(0, span));
			end
			push_item(kd, n, x, y);
		end
		drain();
	endtask

	initial begin
		logic [RANGE_W-1:0] r;
		real rr;
		int span;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_range_read();

		// empty table, boundary distances at the reset range, re-moves and double removes
		push_item(KIND_QUERY, 0, '0, '0);
		push_item(KIND_QUERY_ALT, 63, POS_MAX, POS_MAX);
		push_item(KIND_REMOVE, 5, '0, '0);
		push_item(KIND_MOVE, 0, 16'd0, 16'd0);
		push_item(KIND_MOVE, 1, 16'd499, 16'd0);
		push_item(KIND_MOVE, 2, 16'd0, 16'd500);
		push_item(KIND_MOVE, 63, POS_MAX, POS_MAX);
		push_item(KIND_MOVE, 62, POS_MAX, POS_MAX - 16'd500);
		push_item(KIND_MOVE, 62, POS_MAX, POS_MAX - 16'd499);
		push_item(KIND_MOVE, 1, POS_MAX, POS_MAX);
		push_item(KIND_QUERY_ALT, 1, '0, '0);
		push_item(KIND_MOVE, 3, 16'h5555, 16'hAAAA);
		push_item(KIND_MOVE, 4, 16'hAAAA, 16'h5555);
		push_item(KIND_MOVE, 4, 16'h5555, 16'hAAAA);
		push_item(KIND_REMOVE, 63, '0, '0);
		push_item(KIND_REMOVE, 63, '0, '0);
		push_item(KIND_QUERY, 63, '0, '0);
		push_item(KIND_QUERY, 4, '0, '0);
		drain();
		set_range(RANGE_MAX);
		push_item(KIND_MOVE, 10, 16'd0, 16'd0);
		push_item(KIND_MOVE, 11, POS_MAX, POS_MAX);
		push_item(KIND_QUERY, 0, '0, '0);
		drain();
		set_range('0);
		push_item(KIND_MOVE, 0, 16'd0, 16'd0);
		push_item(KIND_MOVE, 11, 16'd0, 16'd0);
		push_item(KIND_QUERY, 11, '0, '0);
		drain();

		for (int p = 0; p < 7; p++) begin
			case (p)
			0: r = RANGE_RESET;
			1: r = 33'd1;
			2: r = RANGE_W'($urandom_range(100, 4_000_000));
			3: r = RANGE_MAX;
			4: begin
				r = RANGE_W'($urandom());
				r[RANGE_W-1] = 1'($urandom_range(0, 1));
			end
			5: r = '0;
			default: r = RANGE_RESET;
			endcase
			set_range(r);
			rr = r;
			rr = $sqrt(rr);
			span = (rr > 30000.0) ? 65535 : 2 * int'(rr) + 16;
			run_random(210, span);
		end

		drain();
		repeat (ITEM_LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- proximity_neighbor_table.f -----
+incdir+src
src/pnt_pkg.sv
src/pnt_ram.sv
src/pnt_dist.sv
src/pnt_core.sv
src/proximity_neighbor_table.sv
test/tb.sv
